>>> src/gyro_jitter_rms_window_core_assert.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef GYRO_JITTER_RMS_WINDOW_CORE_ASSERT_SVH
`define GYRO_JITTER_RMS_WINDOW_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GJR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GJR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gjr_pkg.sv
package gjr_pkg;

  localparam int unsigned WINDOW_DEFAULT = 20;
  localparam int unsigned RATE_W         = 16;
  localparam int unsigned MAG_W          = 24;
  localparam int unsigned FILL_W         = 5;
  localparam int unsigned FRAC_W         = 8;
  localparam int unsigned SQ_W           = 2 * MAG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_END,
    ST_ROOT_MAG,
    ST_OLD_MUL,
    ST_NEW_MUL,
    ST_SUM_ADD,
    ST_DIV,
    ST_ROOT_RMS,
    ST_FINISH
  } gjr_state_t;

endpackage

>>> src/gjr_in_if.sv
interface gjr_in_if import gjr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

>>> src/gjr_out_if.sv
interface gjr_out_if import gjr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  magnitude;
  logic [MAG_W-1:0]  jitter_rms;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output magnitude, output jitter_rms, output fill_count,
                  input ready);
  modport sink (input valid, input magnitude, input jitter_rms, input fill_count,
                output ready);
endinterface

>>> src/gjr_ram.sv
module gjr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/gyro_jitter_rms_window_core.sv
// Sliding-window RMS of gyro vector magnitude. Each sample word gives
// magnitude = floor(sqrt((x^2+y^2+z^2) * 2^16)) (8 fraction bits), stores it in
// a ring of WINDOW entries and returns the RMS floor(sqrt(sum/fill)) of the
// stored magnitudes with the fill count (1..WINDOW). A new sample is taken only
// once the last result is in the output register. The block uses a restoring
// divider (two quotient bits per cycle) and the shared square-root unit (two
// root bits per cycle, used twice); the three squares and the window update
// share one 24x24 multiplier. Results sit in an output register; the block
// only waits in its last step when the previous result has not yet been taken.
// Ring contents are not cleared after reset.
`include "gyro_jitter_rms_window_core_assert.svh"

module gyro_jitter_rms_window_core
  import gjr_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  gjr_in_if.sink    sample,
  gjr_out_if.source result
);

  localparam int unsigned SLOT_W     = $clog2(WINDOW);
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W      = SQ_W + $clog2(WINDOW);
  localparam int unsigned DIV_W      = SUM_W + (SUM_W % 2);
  localparam int unsigned DIV_STEPS  = DIV_W / 2;
  localparam int unsigned ROOT_STEPS = MAG_W / 2;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned ACC_W      = 2 * RATE_W;
  localparam int unsigned REM_W      = MAG_W + 2;

  gjr_state_t state, state_next;

  logic [RATE_W-1:0] ax, ay, az;
  logic [ACC_W-1:0]  ss;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [SQ_W-1:0]   prod;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem, rem_next;
  logic [MAG_W-1:0]  root, root_next;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W-1:0]  sum, sum_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              full;
  logic              wrap;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [DIV_W-1:0]  div_q, div_q_next;
  logic [CNT_W-1:0]  div_rem, div_rem_next;
  logic [STEP_W-1:0] step;
  logic              ram_we;
  logic [MAG_W-1:0]  ram_rdata;
  logic              out_free;
  logic              root_last, div_last;

  gjr_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (mag),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign sample.ready = (state == ST_IDLE);
  assign out_free     = !result.valid || result.ready;
  assign ram_we       = (state == ST_NEW_MUL);
  assign root_last    = (step == STEP_W'(ROOT_STEPS - 1));
  assign div_last     = (step == STEP_W'(DIV_STEPS - 1));

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_MUL_X:   begin mul_a = MAG_W'(ax); mul_b = MAG_W'(ax); end
      ST_MUL_Y:   begin mul_a = MAG_W'(ay); mul_b = MAG_W'(ay); end
      ST_MUL_Z:   begin mul_a = MAG_W'(az); mul_b = MAG_W'(az); end
      ST_OLD_MUL: begin mul_a = ram_rdata;  mul_b = ram_rdata;  end
      default:    begin mul_a = mag;        mul_b = mag;        end
    endcase
  end

  // square root: two digit-by-digit steps per cycle
  always_comb begin
    logic [REM_W+1:0] r_ext;
    logic [REM_W+1:0] trial;
    logic [REM_W-1:0] r_w;
    logic [MAG_W-1:0] q_w;
    r_w = rem;
    q_w = root;
    for (int i = 0; i < 2; i++) begin
      r_ext = {r_w, rad[SQ_W-1-2*i -: 2]};
      trial = (REM_W + 2)'({q_w, 2'b01});
      if (r_ext >= trial) begin
        r_ext = r_ext - trial;
        q_w   = {q_w[MAG_W-2:0], 1'b1};
      end else begin
        q_w   = {q_w[MAG_W-2:0], 1'b0};
      end
      r_w = r_ext[REM_W-1:0];
    end
    rem_next  = r_w;
    root_next = q_w;
  end

  // restoring divide by fill count: two quotient bits per cycle
  always_comb begin
    logic [CNT_W:0]   r_ext;
    logic [CNT_W-1:0] r_w;
    logic [DIV_W-1:0] q_w;
    r_w = div_rem;
    q_w = div_q;
    for (int i = 0; i < 2; i++) begin
      r_ext = {r_w, q_w[DIV_W-1]};
      q_w   = {q_w[DIV_W-2:0], 1'b0};
      if (r_ext >= {1'b0, fill}) begin
        r_ext  = r_ext - {1'b0, fill};
        q_w[0] = 1'b1;
      end
      r_w = r_ext[CNT_W-1:0];
    end
    div_rem_next = r_w;
    div_q_next   = q_w;
  end

  // window bookkeeping for the sample being stored
  always_comb begin
    wrap      = (slot == SLOT_W'(WINDOW - 1));
    slot_next = wrap ? '0 : slot + 1'b1;
    fill_next = (full || wrap) ? CNT_W'(WINDOW) : CNT_W'(slot) + 1'b1;
    sum_next  = sum + SUM_W'(prod);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (sample.valid) state_next = ST_MUL_X;
      ST_MUL_X:    state_next = ST_MUL_Y;
      ST_MUL_Y:    state_next = ST_MUL_Z;
      ST_MUL_Z:    state_next = ST_MUL_END;
      ST_MUL_END:  state_next = ST_ROOT_MAG;
      ST_ROOT_MAG: if (root_last) state_next = ST_OLD_MUL;
      ST_OLD_MUL:  state_next = ST_NEW_MUL;
      ST_NEW_MUL:  state_next = ST_SUM_ADD;
      ST_SUM_ADD:  state_next = ST_DIV;
      ST_DIV:      if (div_last) state_next = ST_ROOT_RMS;
      ST_ROOT_RMS: if (root_last) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      slot         <= '0;
      full         <= 1'b0;
      sum          <= '0;
      fill         <= '0;
      step         <= '0;
      result.valid <= 1'b0;
    end else begin
      // in the last step a taken word is replaced by the next one below
      if (result.valid && result.ready && (state != ST_FINISH)) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            ax   <= sample.rate_x[RATE_W-1] ? $unsigned(-sample.rate_x)
                                            : $unsigned(sample.rate_x);
            ay   <= sample.rate_y[RATE_W-1] ? $unsigned(-sample.rate_y)
                                            : $unsigned(sample.rate_y);
            az   <= sample.rate_z[RATE_W-1] ? $unsigned(-sample.rate_z)
                                            : $unsigned(sample.rate_z);
            ss   <= '0;
            step <= '0;
          end
        end
        ST_MUL_Y, ST_MUL_Z: begin
          ss <= ss + prod[ACC_W-1:0];
        end
        ST_MUL_END: begin
          rad  <= SQ_W'({ss + prod[ACC_W-1:0], {(2 * FRAC_W){1'b0}}});
          rem  <= '0;
          root <= '0;
          step <= '0;
        end
        ST_ROOT_MAG, ST_ROOT_RMS: begin
          rad  <= {rad[SQ_W-5:0], 4'b0000};
          rem  <= rem_next;
          root <= root_next;
          step <= step + 1'b1;
          if (state == ST_ROOT_MAG && root_last) begin
            mag <= root_next;
          end
        end
        ST_NEW_MUL: begin
          // prod holds the square of the entry about to be overwritten
          if (full) begin
            sum <= sum - SUM_W'(prod);
          end
        end
        ST_SUM_ADD: begin
          sum     <= sum_next;
          div_q   <= DIV_W'(sum_next);
          div_rem <= '0;
          slot    <= slot_next;
          full    <= full | wrap;
          fill    <= fill_next;
          step    <= '0;
        end
        ST_DIV: begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          if (div_last) begin
            rad  <= div_q_next[SQ_W-1:0];
            rem  <= '0;
            root <= '0;
            step <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result.valid      <= 1'b1;
            result.magnitude  <= mag;
            result.jitter_rms <= root;
            result.fill_count <= FILL_W'(fill);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `GJR_ASSERT_NOW(a_slot_range, 1'b1, slot <= SLOT_W'(WINDOW - 1), "write slot past window end")
  `GJR_ASSERT_NEXT(a_full_sticky, full, full, "window full flag dropped")
  `GJR_ASSERT_NOW(a_div_rem_bound, state == ST_DIV, div_rem < fill, "divider remainder too large")
  `GJR_ASSERT_NOW(a_root_rem_bound, (state == ST_ROOT_MAG) || (state == ST_ROOT_RMS), rem <= (REM_W'(root) << 1), "root remainder above twice root")
  `GJR_ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready, "word taken while busy")

endmodule
